// ===== rtl/gtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg: shared definitions of the touch gesture recogniser
// Field widths, register indexes, event and gesture codes, reset values.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int TICK_WIDTH_DEF  = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int KIND_W    = 3;
  localparam int TAP_W     = 16;
  localparam int MOVE_W    = 25;
  localparam int SCALE_W   = 16;
  localparam int ANCHOR_W  = 17;
  localparam int DIST_W    = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SCALE    = 2'd2;

  localparam logic [CFG_W-1:0] PAN_THRESHOLD_RST = 16'd10;
  localparam logic [CFG_W-1:0] DOUBLE_TAP_RST    = 16'd500;
  localparam logic [CFG_W-1:0] VIEW_SCALE_RST    = 16'd256;

  // event codes
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

  // gesture codes
  localparam logic [KIND_W-1:0] KIND_SINGLE_TAP  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DOUBLE_TAP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PAN         = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAN_END     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PINCH_START = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PINCH       = 3'd5;
  localparam logic [KIND_W-1:0] KIND_PINCH_END   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_FAILURE     = 3'd7;

  localparam int PAN_SHIFT   = 16;  // delta * 65536
  localparam int PINCH_SHIFT = 15;  // centre sum delta * 32768

  localparam logic [SCALE_W-1:0] SCALE_MAX    = 16'hFFFF;
  localparam logic [MOVE_W-1:0]  MOVE_POS_LIM = 25'h0FF_FFFF;
  localparam logic [MOVE_W-1:0]  MOVE_NEG_LIM = 25'h100_0000;
  localparam logic [COUNT_W-1:0] PINCH_POINTS = 4'd2;

endpackage

// ===== rtl/gtr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_if: channel interfaces of the touch gesture recogniser
// Touch event channel and gesture result channel, valid/ready.
// ----------------------------------------------------------------------------
interface gtr_in_if import gtr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [MODE_W-1:0]             mode;
  logic [TIME_W-1:0]             event_time;
  logic signed [COORD_WIDTH-1:0] first_global_x;
  logic signed [COORD_WIDTH-1:0] first_global_y;
  logic signed [COORD_WIDTH-1:0] first_content_x;
  logic signed [COORD_WIDTH-1:0] first_content_y;
  logic signed [COORD_WIDTH-1:0] second_global_x;
  logic signed [COORD_WIDTH-1:0] second_global_y;
  logic signed [COORD_WIDTH-1:0] second_content_x;
  logic signed [COORD_WIDTH-1:0] second_content_y;
  logic [COUNT_W-1:0]            point_count;
  logic                          any_pressed;

  modport source (
    output valid, mode, event_time, first_global_x, first_global_y, first_content_x,
           first_content_y, second_global_x, second_global_y, second_content_x,
           second_content_y, point_count, any_pressed,
    input  ready
  );
  modport sink (
    input  valid, mode, event_time, first_global_x, first_global_y, first_content_x,
           first_content_y, second_global_x, second_global_y, second_content_x,
           second_content_y, point_count, any_pressed,
    output ready
  );
endinterface

interface gtr_out_if import gtr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          gesture_kind;
  logic [TIME_W-1:0]          result_time;
  logic signed [TAP_W-1:0]    tap_x;
  logic signed [TAP_W-1:0]    tap_y;
  logic signed [MOVE_W-1:0]   move_dx;
  logic signed [MOVE_W-1:0]   move_dy;
  logic [SCALE_W-1:0]         pinch_scale;
  logic signed [ANCHOR_W-1:0] anchor_x;
  logic signed [ANCHOR_W-1:0] anchor_y;

  modport source (
    output valid, gesture_kind, result_time, tap_x, tap_y, move_dx, move_dy,
           pinch_scale, anchor_x, anchor_y,
    input  ready
  );
  modport sink (
    input  valid, gesture_kind, result_time, tap_x, tap_y, move_dx, move_dy,
           pinch_scale, anchor_x, anchor_y,
    output ready
  );
endinterface

// ===== rtl/gtr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_div: shared unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module gtr_div import gtr_pkg::*; #(
  parameter int NUM_W = 33,
  parameter int DEN_W = DIST_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;   // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        num_r <= {num_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ===== rtl/touch_gesture_recognizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_recognizer: tap, double tap, pan and pinch recogniser
// Gesture state machine with a shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
// Usage
//   in_chan  : touch start / move / end events with two points, or a 1 ms tick.
//   out_chan : at most one gesture result per event, held until transferred.
//   cfg_*    : register writes (pan threshold, double-tap ticks, view scale),
//              only while the block is idle.
// Sequence (COORD_WIDTH = 16)
//   Ticks and plain events: decode, then emit if a result is due, then ready again.
//   Pan move: two passes of the 33-step divider, then emit.
//   Pinch start: the squares, then the 18-step square root, then emit.
//   Pinch move: square root, one multiply, three divisions, then emit
//   (the scale division is skipped when the start distance is zero).
//   In general the divider takes one step per dividend bit, the root one per root bit.
//   One event is in work at a time; in_chan.ready is high only when idle.
// Reset
//   Synchronous, active low: gesture idle, registers at their defaults, no
//   result pending.
// Stalls
//   The next event is taken while a result waits in the output register; if
//   that event also yields a result, the block holds it until the transfer.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer import gtr_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gtr_in_if.sink               in_chan,
  gtr_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = CW + 1;            // point difference / pair sum
  localparam int DW    = CW + 2;            // difference of pair sums
  localparam int RT_W  = CW + 2;            // square root
  localparam int SQ_W  = 2 * RT_W;          // radicand
  localparam int REM_W = RT_W + 3;
  localparam int NUM_W = CW + 17;           // dividend
  localparam int MW    = (RT_W > SCALE_W) ? RT_W : SCALE_W;
  localparam int TH_W  = (PW > CFG_W) ? PW : CFG_W;
  localparam int TG_W  = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam int SQC_W = $clog2(RT_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQ_X, S_SQ_Y, S_SQRT, S_MUL,
    S_DIV_SC, S_DIV_X, S_DIV_Y, S_EMIT
  } fsm_t;

  typedef enum logic [2:0] {
    G_IDLE, G_SINGLE, G_WAIT, G_DOUBLE, G_PAN, G_PINCH
  } gst_t;

  typedef enum logic [1:0] {J_PAN, J_PSTART, J_PMOVE} job_t;

  // sequencer and gesture state
  fsm_t fsm_r;
  gst_t gst_r;
  job_t job_r;
  logic launch_r;

  // configuration
  logic [CFG_W-1:0] pan_thr_r, dtt_r, vscale_r;

  // captured event
  logic [MODE_W-1:0]    mode_r;
  logic [TIME_W-1:0]    time_r;
  logic signed [CW-1:0] g1x_r, g1y_r, c1x_r, c1y_r, g2x_r, g2y_r, c2x_r, c2y_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic                 prs_r;

  // gesture context
  logic signed [CW-1:0]   org_x_r, org_y_r, last_x_r, last_y_r;
  logic [TIME_W-1:0]      tap_time_r;
  logic [TICK_WIDTH-1:0]  wt_r;
  logic [DIST_W-1:0]      sd_r;
  logic [SCALE_W-1:0]     ss_r;
  logic signed [PW-1:0]   cc_x_r, cc_y_r, ls_x_r, ls_y_r;

  // arithmetic
  logic signed [DW-1:0] dlt_x_r, dlt_y_r;
  logic [SQ_W-1:0]      acc_r;
  logic [REM_W-1:0]     rem_r;
  logic [RT_W-1:0]      root_r;
  logic [SQC_W-1:0]     sq_cnt_r;
  logic [NUM_W-1:0]     prod_r;

  // working result
  logic [KIND_W-1:0]          res_kind_r;
  logic [TIME_W-1:0]          res_time_r;
  logic [TAP_W-1:0]           res_tap_x_r, res_tap_y_r;
  logic [MOVE_W-1:0]          res_dx_r, res_dy_r;
  logic [SCALE_W-1:0]         res_scale_r;
  logic [ANCHOR_W-1:0]        res_anc_x_r, res_anc_y_r;

  // output register
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [TAP_W-1:0]    out_tap_x_r, out_tap_y_r;
  logic [MOVE_W-1:0]   out_dx_r, out_dy_r;
  logic [SCALE_W-1:0]  out_scale_r;
  logic [ANCHOR_W-1:0] out_anc_x_r, out_anc_y_r;

  // ---- coordinate helpers ---------------------------------------------------
  function automatic logic [TAP_W-1:0] to_tap(input logic signed [CW-1:0] v);
    logic signed [31:0] e;
    e = 32'(v);
    return e[TAP_W-1:0];
  endfunction

  function automatic logic [ANCHOR_W-1:0] to_anchor(input logic signed [PW-1:0] v);
    logic signed [31:0] e;
    e = 32'(v);
    return e[ANCHOR_W-1:0];
  endfunction

  // truncated quotient magnitude back to a saturated signed delta
  function automatic logic [MOVE_W-1:0] sat_move(input logic [NUM_W-1:0] q,
                                                 input logic neg);
    logic [NUM_W-1:0] nq;
    nq = NUM_W'(0) - q;
    if (!neg) return (q > NUM_W'(MOVE_POS_LIM)) ? MOVE_POS_LIM : q[MOVE_W-1:0];
    return (q > NUM_W'(MOVE_NEG_LIM)) ? MOVE_NEG_LIM : nq[MOVE_W-1:0];
  endfunction

  // ---- event decode terms ---------------------------------------------------
  logic signed [PW-1:0] org_dx, org_dy, pan_dx, pan_dy, gs_x, gs_y, cs_x, cs_y;
  logic signed [PW-1:0] pp_dx, pp_dy;
  logic signed [DW-1:0] sum_dx, sum_dy;
  logic [PW-1:0]        org_mx, org_my, pp_mx, pp_my;
  logic                 beyond;

  assign org_dx = PW'(g1x_r) - PW'(org_x_r);
  assign org_dy = PW'(g1y_r) - PW'(org_y_r);
  assign org_mx = org_dx[PW-1] ? PW'(-org_dx) : PW'(org_dx);
  assign org_my = org_dy[PW-1] ? PW'(-org_dy) : PW'(org_dy);
  assign beyond = (TH_W'(org_mx) > TH_W'(pan_thr_r)) || (TH_W'(org_my) > TH_W'(pan_thr_r));

  assign pan_dx = PW'(g1x_r) - PW'(last_x_r);
  assign pan_dy = PW'(g1y_r) - PW'(last_y_r);
  assign gs_x   = PW'(g1x_r) + PW'(g2x_r);
  assign gs_y   = PW'(g1y_r) + PW'(g2y_r);
  assign cs_x   = PW'(c1x_r) + PW'(c2x_r);
  assign cs_y   = PW'(c1y_r) + PW'(c2y_r);
  assign sum_dx = DW'(gs_x) - DW'(ls_x_r);
  assign sum_dy = DW'(gs_y) - DW'(ls_y_r);

  // point pair separation for the distance
  assign pp_dx = PW'(g1x_r) - PW'(g2x_r);
  assign pp_dy = PW'(g1y_r) - PW'(g2y_r);
  assign pp_mx = pp_dx[PW-1] ? PW'(-pp_dx) : PW'(pp_dx);
  assign pp_my = pp_dy[PW-1] ? PW'(-pp_dy) : PW'(pp_dy);

  // double-tap timeout; the counter sticks at its maximum
  logic [TICK_WIDTH-1:0] wt_inc;
  logic [TG_W-1:0]       tick_target;
  logic                  tick_fire;

  assign wt_inc      = (wt_r != '1) ? wt_r + 1'b1 : wt_r;
  assign tick_target = (TG_W'(dtt_r) < TG_W'({TICK_WIDTH{1'b1}})) ? TG_W'(dtt_r)
                                                                  : TG_W'({TICK_WIDTH{1'b1}});
  assign tick_fire   = TG_W'(wt_inc) >= tick_target;

  // ---- shared multiplier ----------------------------------------------------
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;

  always_comb begin
    case (fsm_r)
      S_SQ_X: begin
        mul_a = MW'(pp_mx);
        mul_b = MW'(pp_mx);
      end
      S_SQ_Y: begin
        mul_a = MW'(pp_my);
        mul_b = MW'(pp_my);
      end
      S_MUL: begin
        mul_a = MW'(ss_r);
        mul_b = MW'(root_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---- square root step, two radicand bits a cycle --------------------------
  logic [REM_W-1:0] rem_sh, trial, rem_nxt;
  logic [RT_W-1:0]  root_nxt;
  logic             sq_fit;

  assign rem_sh   = {rem_r[REM_W-3:0], acc_r[SQ_W-1 -: 2]};
  assign trial    = REM_W'({root_r, 2'b01});
  assign sq_fit   = rem_sh >= trial;
  assign rem_nxt  = sq_fit ? rem_sh - trial : rem_sh;
  assign root_nxt = {root_r[RT_W-2:0], sq_fit};

  // ---- shared divider -------------------------------------------------------
  logic [DW-1:0]     mag_x, mag_y;
  logic [DIST_W-1:0] vs;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DIST_W-1:0] div_den;

  assign mag_x = dlt_x_r[DW-1] ? DW'(-dlt_x_r) : DW'(dlt_x_r);
  assign mag_y = dlt_y_r[DW-1] ? DW'(-dlt_y_r) : DW'(dlt_y_r);
  assign vs    = (vscale_r == '0) ? DIST_W'(1) : DIST_W'(vscale_r);

  assign div_start = launch_r &&
                     (fsm_r == S_DIV_SC || fsm_r == S_DIV_X || fsm_r == S_DIV_Y);

  always_comb begin
    case (fsm_r)
      S_DIV_SC: begin
        div_num = prod_r;
        div_den = sd_r;
      end
      S_DIV_X: begin
        div_num = (job_r == J_PAN) ? NUM_W'(mag_x) << PAN_SHIFT
                                   : NUM_W'(mag_x) << PINCH_SHIFT;
        div_den = vs;
      end
      S_DIV_Y: begin
        div_num = (job_r == J_PAN) ? NUM_W'(mag_y) << PAN_SHIFT
                                   : NUM_W'(mag_y) << PINCH_SHIFT;
        div_den = vs;
      end
      default: begin
        div_num = '0;
        div_den = vs;
      end
    endcase
  end

  gtr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIST_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---- sequencer ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      gst_r       <= G_IDLE;
      job_r       <= J_PAN;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pan_thr_r   <= PAN_THRESHOLD_RST;
      dtt_r       <= DOUBLE_TAP_RST;
      vscale_r    <= VIEW_SCALE_RST;
      org_x_r     <= '0;
      org_y_r     <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      tap_time_r  <= '0;
      wt_r        <= '0;
      sd_r        <= '0;
      ss_r        <= '0;
      cc_x_r      <= '0;
      cc_y_r      <= '0;
      ls_x_r      <= '0;
      ls_y_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PAN_THRESHOLD: pan_thr_r <= cfg_wdata;
          CFG_DOUBLE_TAP:    dtt_r     <= cfg_wdata;
          CFG_VIEW_SCALE:    vscale_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      if (div_start) launch_r <= 1'b0;

      case (fsm_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            mode_r <= in_chan.mode;
            time_r <= in_chan.event_time;
            g1x_r  <= in_chan.first_global_x;
            g1y_r  <= in_chan.first_global_y;
            c1x_r  <= in_chan.first_content_x;
            c1y_r  <= in_chan.first_content_y;
            g2x_r  <= in_chan.second_global_x;
            g2y_r  <= in_chan.second_global_y;
            c2x_r  <= in_chan.second_content_x;
            c2y_r  <= in_chan.second_content_y;
            cnt_r  <= in_chan.point_count;
            prs_r  <= in_chan.any_pressed;
            fsm_r  <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_kind_r  <= KIND_FAILURE;
          res_time_r  <= time_r;
          res_tap_x_r <= '0;
          res_tap_y_r <= '0;
          res_dx_r    <= '0;
          res_dy_r    <= '0;
          res_scale_r <= '0;
          res_anc_x_r <= '0;
          res_anc_y_r <= '0;
          fsm_r       <= S_IDLE;

          if (mode_r == MODE_TICK) begin
            if (gst_r == G_WAIT) begin
              if (tick_fire) begin
                res_kind_r  <= KIND_SINGLE_TAP;
                res_time_r  <= tap_time_r;
                res_tap_x_r <= to_tap(org_x_r);
                res_tap_y_r <= to_tap(org_y_r);
                gst_r       <= G_IDLE;
                wt_r        <= '0;
                fsm_r       <= S_EMIT;
              end else begin
                wt_r <= wt_inc;
              end
            end
          end else begin
            last_x_r <= g1x_r;
            last_y_r <= g1y_r;
            case (gst_r)
              G_IDLE: begin
                if (mode_r == MODE_START) begin
                  gst_r   <= G_SINGLE;
                  org_x_r <= g1x_r;
                  org_y_r <= g1y_r;
                end
              end
              G_SINGLE, G_DOUBLE: begin
                if (mode_r == MODE_MOVE) begin
                  if (beyond) begin
                    gst_r      <= G_PAN;
                    res_kind_r <= KIND_PAN;
                    dlt_x_r    <= DW'(pan_dx);
                    dlt_y_r    <= DW'(pan_dy);
                    job_r      <= J_PAN;
                    launch_r   <= 1'b1;
                    fsm_r      <= S_DIV_X;
                  end
                end else if (mode_r == MODE_END) begin
                  if (gst_r == G_SINGLE) begin
                    gst_r      <= G_WAIT;
                    tap_time_r <= time_r;
                    wt_r       <= '0;
                  end else begin
                    gst_r       <= G_IDLE;
                    res_kind_r  <= KIND_DOUBLE_TAP;
                    res_tap_x_r <= to_tap(g1x_r);
                    res_tap_y_r <= to_tap(g1y_r);
                    fsm_r       <= S_EMIT;
                  end
                end else begin
                  gst_r      <= G_PINCH;
                  ss_r       <= vscale_r;
                  cc_x_r     <= cs_x;
                  cc_y_r     <= cs_y;
                  ls_x_r     <= gs_x;
                  ls_y_r     <= gs_y;
                  res_kind_r <= KIND_PINCH_START;
                  job_r      <= J_PSTART;
                  fsm_r      <= S_SQ_X;
                end
              end
              G_WAIT: begin
                wt_r <= '0;
                if (mode_r == MODE_START) begin
                  gst_r <= G_DOUBLE;
                end else begin
                  gst_r      <= G_IDLE;
                  tap_time_r <= '0;
                  sd_r       <= '0;
                  ss_r       <= '0;
                  res_kind_r <= KIND_FAILURE;
                  fsm_r      <= S_EMIT;
                end
              end
              G_PAN: begin
                if (mode_r == MODE_MOVE) begin
                  res_kind_r <= KIND_PAN;
                  dlt_x_r    <= DW'(pan_dx);
                  dlt_y_r    <= DW'(pan_dy);
                  job_r      <= J_PAN;
                  launch_r   <= 1'b1;
                  fsm_r      <= S_DIV_X;
                end else if (mode_r == MODE_END) begin
                  gst_r      <= G_IDLE;
                  res_kind_r <= KIND_PAN_END;
                  fsm_r      <= S_EMIT;
                end else begin
                  gst_r      <= G_PINCH;
                  ss_r       <= vscale_r;
                  cc_x_r     <= cs_x;
                  cc_y_r     <= cs_y;
                  ls_x_r     <= gs_x;
                  ls_y_r     <= gs_y;
                  res_kind_r <= KIND_PINCH_START;
                  job_r      <= J_PSTART;
                  fsm_r      <= S_SQ_X;
                end
              end
              G_PINCH: begin
                if (cnt_r < PINCH_POINTS) begin
                  // lost a finger: failure and back to idle
                  gst_r      <= G_IDLE;
                  tap_time_r <= '0;
                  wt_r       <= '0;
                  sd_r       <= '0;
                  ss_r       <= '0;
                  res_kind_r <= KIND_FAILURE;
                  fsm_r      <= S_EMIT;
                end else if (mode_r == MODE_MOVE) begin
                  ls_x_r      <= gs_x;
                  ls_y_r      <= gs_y;
                  dlt_x_r     <= sum_dx;
                  dlt_y_r     <= sum_dy;
                  res_kind_r  <= KIND_PINCH;
                  res_anc_x_r <= to_anchor(cc_x_r);
                  res_anc_y_r <= to_anchor(cc_y_r);
                  job_r       <= J_PMOVE;
                  fsm_r       <= S_SQ_X;
                end else if (mode_r == MODE_END) begin
                  if (prs_r) begin
                    gst_r <= G_PAN;
                  end else begin
                    gst_r      <= G_IDLE;
                    tap_time_r <= '0;
                    wt_r       <= '0;
                    sd_r       <= '0;
                    ss_r       <= '0;
                  end
                  res_kind_r <= KIND_PINCH_END;
                  fsm_r      <= S_EMIT;
                end
              end
              default: begin
                gst_r      <= G_IDLE;
                tap_time_r <= '0;
                wt_r       <= '0;
                sd_r       <= '0;
                ss_r       <= '0;
              end
            endcase
          end
        end

        S_SQ_X: begin
          acc_r <= SQ_W'(mul_p);
          fsm_r <= S_SQ_Y;
        end

        S_SQ_Y: begin
          acc_r    <= acc_r + SQ_W'(mul_p);
          rem_r    <= '0;
          root_r   <= '0;
          sq_cnt_r <= SQC_W'(RT_W);
          fsm_r    <= S_SQRT;
        end

        S_SQRT: begin
          acc_r    <= acc_r << 2;
          rem_r    <= rem_nxt;
          root_r   <= root_nxt;
          sq_cnt_r <= sq_cnt_r - 1'b1;
          if (sq_cnt_r == SQC_W'(1)) begin
            if (job_r == J_PSTART) begin
              sd_r  <= DIST_W'(root_nxt);
              fsm_r <= S_EMIT;
            end else begin
              fsm_r <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod_r   <= NUM_W'(mul_p);
          launch_r <= 1'b1;
          if (sd_r == '0) begin
            res_scale_r <= SCALE_MAX;
            fsm_r       <= S_DIV_X;
          end else begin
            fsm_r <= S_DIV_SC;
          end
        end

        S_DIV_SC: begin
          if (div_done) begin
            res_scale_r <= (div_quot > NUM_W'(SCALE_MAX)) ? SCALE_MAX
                                                          : div_quot[SCALE_W-1:0];
            launch_r    <= 1'b1;
            fsm_r       <= S_DIV_X;
          end
        end

        S_DIV_X: begin
          if (div_done) begin
            res_dx_r <= sat_move(div_quot, dlt_x_r[DW-1]);
            launch_r <= 1'b1;
            fsm_r    <= S_DIV_Y;
          end
        end

        S_DIV_Y: begin
          if (div_done) begin
            res_dy_r <= sat_move(div_quot, dlt_y_r[DW-1]);
            fsm_r    <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_time_r  <= res_time_r;
            out_tap_x_r <= res_tap_x_r;
            out_tap_y_r <= res_tap_y_r;
            out_dx_r    <= res_dx_r;
            out_dy_r    <= res_dy_r;
            out_scale_r <= res_scale_r;
            out_anc_x_r <= res_anc_x_r;
            out_anc_y_r <= res_anc_y_r;
            fsm_r       <= S_IDLE;
          end
        end

        default: fsm_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready         = (fsm_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.gesture_kind = out_kind_r;
  assign out_chan.result_time  = out_time_r;
  assign out_chan.tap_x        = out_tap_x_r;
  assign out_chan.tap_y        = out_tap_y_r;
  assign out_chan.move_dx      = out_dx_r;
  assign out_chan.move_dy      = out_dy_r;
  assign out_chan.pinch_scale  = out_scale_r;
  assign out_chan.anchor_x     = out_anc_x_r;
  assign out_chan.anchor_y     = out_anc_y_r;

endmodule

// ===== rtl/gtr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_checker: port-level checks of the touch gesture recogniser
// Watches the channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module gtr_checker import gtr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [TIME_W-1:0] out_time
);

  // one event at a time: a transfer closes the input
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after an event transfer");

  // a fresh result only appears as the event in work finishes
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no event in work");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_time))
    else $error("result changed while stalled");

endmodule

bind touch_gesture_recognizer gtr_checker u_gtr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.gesture_kind),
  .out_time  (out_chan.result_time)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the touch gesture recogniser
// Random and directed touch events feed the block through a valid/ready
// channel. A predictor follows the gesture state machine for every accepted
// event, and each gesture result that comes out is compared with it.
// ----------------------------------------------------------------------------
module tb;
  import gtr_pkg::*;

  // Gesture states of the predictor
  typedef enum logic [2:0] {
    G_IDLE, G_SINGLE, G_WAIT, G_DOUBLE, G_PAN, G_PINCH
  } gest_state_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  t;
    logic signed [15:0] g1x, g1y, c1x, c1y, g2x, g2y, c2x, c2y;
    logic [COUNT_W-1:0] cnt;
    logic               pressed;
  } touch_evt_t;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [TIME_W-1:0]          t;
    logic signed [TAP_W-1:0]    tx, ty;
    logic signed [MOVE_W-1:0]   dx, dy;
    logic [SCALE_W-1:0]         sc;
    logic signed [ANCHOR_W-1:0] ax, ay;
  } gesture_t;

  localparam int  HALF_PERIOD = 6;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  N_RANDOM    = 1200;
  localparam int  TICK_MAX    = 65535;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_PAN_THRESHOLD;
  logic [CFG_W-1:0] cfg_wdata = '0;

  gtr_in_if  in_chan ();
  gtr_out_if out_chan ();

  touch_gesture_recognizer dut (
    .clk, .rst_n, .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor state and registers
  gest_state_t g_state;
  longint      origin_x, origin_y, last_x, last_y;
  logic [31:0] tap_time;
  int unsigned wait_ticks, start_dist, start_scale;
  longint      centre_cx, centre_cy, last_sum_x, last_sum_y;
  int unsigned r_pan_thr, r_dtap, r_vscale;

  touch_evt_t  pending_events[$];
  gesture_t    expected_gestures[$];
  int          n_errors = 0;
  longint      cycle = 0;
  bit          random_idle = 1'b1;   // cleared for the no-idle stretch
  bit          sink_hold = 1'b0;     // long back-pressure window

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Delta in 1/factor pixel units divided by view scale, saturated to 25 bits
  function automatic logic [MOVE_W-1:0] scaled_delta(longint d, longint factor);
    longint s, q;
    s = (r_vscale != 0) ? longint'(r_vscale) : 64'sd1;
    q = (d * factor) / s;
    if (q > 16777215) q = 16777215;
    if (q < -16777216) q = -16777216;
    return q[MOVE_W-1:0];
  endfunction

  function automatic void clear_gesture();
    g_state = G_IDLE;
    tap_time = '0;
    wait_ticks = 0;
    start_dist = 0;
    start_scale = 0;
  endfunction

  function automatic void predict_reset();
    r_pan_thr = PAN_THRESHOLD_RST;
    r_dtap = DOUBLE_TAP_RST;
    r_vscale = VIEW_SCALE_RST;
    origin_x = 0; origin_y = 0; last_x = 0; last_y = 0;
    centre_cx = 0; centre_cy = 0; last_sum_x = 0; last_sum_y = 0;
    clear_gesture();
  endfunction

  function automatic gesture_t blank(logic [KIND_W-1:0] k, logic [31:0] t);
    gesture_t r;
    r = '0;
    r.kind = k;
    r.t = t;
    return r;
  endfunction

  function automatic gesture_t pan_gesture(touch_evt_t e);
    gesture_t r;
    r = blank(KIND_PAN, e.t);
    g_state = G_PAN;
    r.dx = scaled_delta(longint'(e.g1x) - last_x, 65536);
    r.dy = scaled_delta(longint'(e.g1y) - last_y, 65536);
    return r;
  endfunction

  function automatic gesture_t pinch_begin(touch_evt_t e);
    longint ddx, ddy;
    ddx = longint'(e.g1x) - longint'(e.g2x);
    ddy = longint'(e.g1y) - longint'(e.g2y);
    g_state = G_PINCH;
    start_dist = isqrt(ddx * ddx + ddy * ddy) & 32'h1FFFF;
    start_scale = r_vscale;
    centre_cx = longint'(e.c1x) + longint'(e.c2x);
    centre_cy = longint'(e.c1y) + longint'(e.c2y);
    last_sum_x = longint'(e.g1x) + longint'(e.g2x);
    last_sum_y = longint'(e.g1y) + longint'(e.g2y);
    return blank(KIND_PINCH_START, e.t);
  endfunction

  // Advance the predictor by one event; queue a result if one is due
  function automatic void predict_gesture(touch_evt_t e);
    gesture_t r;
    bit has;
    longint adx, ady, sx, sy, ddx, ddy, cur, sc;
    int unsigned target;
    has = 1'b0;
    r = '0;
    if (e.mode == MODE_TICK) begin
      if (g_state == G_WAIT) begin
        target = (r_dtap < TICK_MAX) ? r_dtap : TICK_MAX;
        if (wait_ticks < TICK_MAX) wait_ticks++;
        if (wait_ticks >= target) begin
          r = blank(KIND_SINGLE_TAP, tap_time);
          r.tx = origin_x[15:0];
          r.ty = origin_y[15:0];
          has = 1'b1;
          g_state = G_IDLE;
          wait_ticks = 0;
        end
      end
      if (has) expected_gestures.push_back(r);
      return;
    end
    case (g_state)
      G_IDLE: begin
        if (e.mode == MODE_START) begin
          g_state = G_SINGLE;
          origin_x = e.g1x;
          origin_y = e.g1y;
        end
      end
      G_SINGLE, G_DOUBLE: begin
        if (e.mode == MODE_MOVE) begin
          adx = longint'(e.g1x) - origin_x;
          ady = longint'(e.g1y) - origin_y;
          if (adx < 0) adx = -adx;
          if (ady < 0) ady = -ady;
          if ((adx > ady ? adx : ady) > longint'(r_pan_thr)) begin
            r = pan_gesture(e);
            has = 1'b1;
          end
        end else if (e.mode == MODE_END) begin
          if (g_state == G_SINGLE) begin
            g_state = G_WAIT;
            tap_time = e.t;
            wait_ticks = 0;
          end else begin
            g_state = G_IDLE;
            r = blank(KIND_DOUBLE_TAP, e.t);
            r.tx = e.g1x;
            r.ty = e.g1y;
            has = 1'b1;
          end
        end else begin
          r = pinch_begin(e);
          has = 1'b1;
        end
      end
      G_WAIT: begin
        wait_ticks = 0;
        if (e.mode == MODE_START) begin
          g_state = G_DOUBLE;
        end else begin
          clear_gesture();
          r = blank(KIND_FAILURE, e.t);
          has = 1'b1;
        end
      end
      G_PAN: begin
        if (e.mode == MODE_MOVE) begin
          r = pan_gesture(e);
        end else if (e.mode == MODE_END) begin
          g_state = G_IDLE;
          r = blank(KIND_PAN_END, e.t);
        end else begin
          r = pinch_begin(e);
        end
        has = 1'b1;
      end
      G_PINCH: begin
        if (e.cnt < PINCH_POINTS) begin
          clear_gesture();
          r = blank(KIND_FAILURE, e.t);
          has = 1'b1;
        end else if (e.mode == MODE_MOVE) begin
          sx = longint'(e.g1x) + longint'(e.g2x);
          sy = longint'(e.g1y) + longint'(e.g2y);
          ddx = longint'(e.g1x) - longint'(e.g2x);
          ddy = longint'(e.g1y) - longint'(e.g2y);
          cur = isqrt(ddx * ddx + ddy * ddy);
          sc = (start_dist == 0) ? 65535 : (longint'(start_scale) * cur) / start_dist;
          if (sc > 65535) sc = 65535;
          r = blank(KIND_PINCH, e.t);
          r.dx = scaled_delta(sx - last_sum_x, 32768);
          r.dy = scaled_delta(sy - last_sum_y, 32768);
          r.sc = sc[15:0];
          r.ax = centre_cx[16:0];
          r.ay = centre_cy[16:0];
          last_sum_x = sx;
          last_sum_y = sy;
          has = 1'b1;
        end else if (e.mode == MODE_END) begin
          // still pressed: carry on as a pan; otherwise quiet reset
          if (e.pressed) g_state = G_PAN;
          else clear_gesture();
          r = blank(KIND_PINCH_END, e.t);
          has = 1'b1;
        end
      end
      default: clear_gesture();
    endcase
    last_x = e.g1x;
    last_y = e.g1y;
    if (has) expected_gestures.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // ---- driver: one event offered at a time from the pending queue ----------
  touch_evt_t cur_evt;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      // a transfer this edge retires the event at the head of the queue
      if (in_chan.valid && in_chan.ready) begin
        predict_gesture(cur_evt);
        void'(pending_events.pop_front());
      end
      if ((!in_chan.valid || in_chan.ready) && pending_events.size() > 0 &&
          !(random_idle && $urandom_range(99) < 36)) begin
        cur_evt = pending_events[0];
        in_chan.valid <= 1'b1;
        in_chan.mode <= cur_evt.mode;
        in_chan.event_time <= cur_evt.t;
        in_chan.first_global_x <= cur_evt.g1x;
        in_chan.first_global_y <= cur_evt.g1y;
        in_chan.first_content_x <= cur_evt.c1x;
        in_chan.first_content_y <= cur_evt.c1y;
        in_chan.second_global_x <= cur_evt.g2x;
        in_chan.second_global_y <= cur_evt.g2y;
        in_chan.second_content_x <= cur_evt.c2x;
        in_chan.second_content_y <= cur_evt.c2y;
        in_chan.point_count <= cur_evt.cnt;
        in_chan.any_pressed <= cur_evt.pressed;
      end else if (in_chan.ready) begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // ---- monitor: result sink with random back-pressure ---------------------
  gesture_t got, want;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.kind = out_chan.gesture_kind;
        got.t = out_chan.result_time;
        got.tx = out_chan.tap_x;
        got.ty = out_chan.tap_y;
        got.dx = out_chan.move_dx;
        got.dy = out_chan.move_dy;
        got.sc = out_chan.pinch_scale;
        got.ax = out_chan.anchor_x;
        got.ay = out_chan.anchor_y;
        if (expected_gestures.size() == 0) begin
          report_mismatch("unexpected result kind", got.kind, 0);
        end else begin
          want = expected_gestures.pop_front();
          if (got.kind != want.kind) report_mismatch("gesture_kind", got.kind, want.kind);
          if (got.t != want.t) report_mismatch("result_time", got.t, want.t);
          if (got.tx != want.tx) report_mismatch("tap_x", got.tx, want.tx);
          if (got.ty != want.ty) report_mismatch("tap_y", got.ty, want.ty);
          if (got.dx != want.dx) report_mismatch("move_dx", got.dx, want.dx);
          if (got.dy != want.dy) report_mismatch("move_dy", got.dy, want.dy);
          if (got.sc != want.sc) report_mismatch("pinch_scale", got.sc, want.sc);
          if (got.ax != want.ax) report_mismatch("anchor_x", got.ax, want.ax);
          if (got.ay != want.ay) report_mismatch("anchor_y", got.ay, want.ay);
        end
      end
      out_chan.ready <= !sink_hold && !(random_idle && $urandom_range(99) < 36);
    end
  end

  // ---- stimulus helpers ---------------------------------------------------
  logic [31:0] ev_clock = 32'd1000;

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic push_evt(logic [MODE_W-1:0] m, logic signed [15:0] x, logic signed [15:0] y,
                          logic [COUNT_W-1:0] n, bit pr);
    touch_evt_t e;
    e.mode = m;
    ev_clock += $urandom_range(20);
    e.t = ($urandom_range(30) == 0) ? $urandom : ev_clock;
    e.g1x = x;
    e.g1y = y;
    e.c1x = rnd_coord();
    e.c1y = rnd_coord();
    e.g2x = rnd_coord();
    e.g2y = rnd_coord();
    e.c2x = rnd_coord();
    e.c2y = rnd_coord();
    e.cnt = n;
    e.pressed = pr;
    pending_events.push_back(e);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_evt(MODE_TICK, rnd_coord(), rnd_coord(), $urandom, $urandom);
  endtask

  task automatic wait_drain();
    while (pending_events.size() > 0 || in_chan.valid || expected_gestures.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);   // covers the slowest event that yields nothing
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PAN_THRESHOLD: r_pan_thr = v;
      CFG_DOUBLE_TAP:    r_dtap = v;
      default:           r_vscale = v;
    endcase
  endtask

  // One gesture sequence with random content, mostly well formed
  task automatic push_sequence();
    logic signed [15:0] x, y;
    int k;
    x = rnd_coord();
    y = rnd_coord();
    case ($urandom_range(9))
      0, 1: begin  // single tap, timed out when the timeout is short
        push_evt(MODE_START, x, y, 1, 1);
        push_evt(MODE_END, x, y, 1, 0);
        push_ticks(r_dtap < 40 ? r_dtap + 1 : $urandom_range(6));
      end
      2: begin  // double tap
        push_evt(MODE_START, x, y, 1, 1);
        push_evt(MODE_END, x, y, 1, 0);
        push_ticks($urandom_range(2));
        push_evt(MODE_START, x, y, 1, 1);
        push_evt(MODE_END, x + 1, y, 1, 0);
      end
      3, 4: begin  // pan
        push_evt(MODE_START, x, y, 1, 1);
        k = $urandom_range(1, 5);
        repeat (k) begin
          x += 16'($signed($urandom_range(60)) - 30);
          y += 16'($signed($urandom_range(60)) - 30);
          push_evt(MODE_MOVE, x, y, 1, 1);
        end
        push_evt(MODE_END, x, y, 1, 0);
      end
      5, 6, 7: begin  // pinch, ending in pan, reset or failure
        push_evt(MODE_START, x, y, 1, 1);
        push_evt(MODE_START, x, y, 2, 1);
        repeat ($urandom_range(1, 4)) push_evt(MODE_MOVE, rnd_coord(), rnd_coord(), 2, 1);
        case ($urandom_range(2))
          0: push_evt(MODE_END, x, y, 2, 0);
          1: begin
            push_evt(MODE_END, x, y, 2, 1);
            push_evt(MODE_END, x, y, 1, 0);
          end
          default: push_evt(MODE_MOVE, x, y, $urandom_range(1), 1);
        endcase
      end
      default: begin  // noise and broken sequences
        repeat ($urandom_range(1, 4))
          push_evt(2'($urandom), rnd_coord(), rnd_coord(), 4'($urandom), 1'($urandom));
      end
    endcase
  endtask

  // ---- main sequence ------------------------------------------------------
  initial begin
    in_chan.valid = 1'b0;
    in_chan.mode = MODE_TICK;
    in_chan.event_time = '0;
    in_chan.first_global_x = '0;
    in_chan.first_global_y = '0;
    in_chan.first_content_x = '0;
    in_chan.first_content_y = '0;
    in_chan.second_global_x = '0;
    in_chan.second_global_y = '0;
    in_chan.second_content_x = '0;
    in_chan.second_content_y = '0;
    in_chan.point_count = '0;
    in_chan.any_pressed = 1'b0;
    out_chan.ready = 1'b0;
    predict_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tap with short timeout, double tap, extreme pan and pinch
    write_reg(CFG_DOUBLE_TAP, 16'd2);
    push_evt(MODE_START, 16'sh7FFF, 16'sh8000, 1, 1);
    push_evt(MODE_END, 16'sh7FFF, 16'sh8000, 1, 0);
    push_ticks(2);
    push_evt(MODE_START, 0, 0, 1, 1);
    push_evt(MODE_END, 0, 0, 1, 0);
    push_evt(MODE_START, 5, 5, 1, 1);
    push_evt(MODE_END, -5, 5, 1, 0);
    push_evt(MODE_START, 16'sh8000, 16'sh8000, 1, 1);
    push_evt(MODE_MOVE, 16'sh7FFF, 16'sh7FFF, 1, 1);
    push_evt(MODE_START, 0, 0, 2, 1);   // pinch start from pan
    push_evt(MODE_MOVE, 3, 4, 2, 1);
    push_evt(MODE_END, 0, 0, 2, 1);     // pinch end, back to pan
    push_evt(MODE_END, 0, 0, 1, 0);
    push_evt(MODE_START, 0, 0, 1, 1);
    push_evt(MODE_END, 0, 0, 1, 0);
    push_evt(MODE_MOVE, 0, 0, 1, 1);    // failure while waiting
    push_evt(MODE_END, 0, 0, 0, 0);     // ignored when idle
    wait_drain();

    // settings sweep, extremes included; first phase runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_PAN_THRESHOLD, 0); write_reg(CFG_VIEW_SCALE, 1);
                 write_reg(CFG_DOUBLE_TAP, 1); end
        1: begin write_reg(CFG_PAN_THRESHOLD, 16'hFFFF); write_reg(CFG_VIEW_SCALE, 16'hFFFF);
                 write_reg(CFG_DOUBLE_TAP, 16'hFFFF); end
        2: begin write_reg(CFG_VIEW_SCALE, 0); write_reg(CFG_DOUBLE_TAP, 0);
                 write_reg(CFG_PAN_THRESHOLD, 16'($urandom)); end
        default: begin write_reg(CFG_PAN_THRESHOLD, $urandom_range(40));
                 write_reg(CFG_VIEW_SCALE, $urandom_range(1, 1024));
                 write_reg(CFG_DOUBLE_TAP, $urandom_range(1, 8)); end
      endcase
      random_idle = (ph != 0);
      while (pending_events.size() < N_RANDOM / 6) push_sequence();
      if (ph == 3) begin
        // hold the sink off for a long while so the block backs up
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      wait_drain();
    end

    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/gtr_pkg.sv
rtl/gtr_if.sv
rtl/gtr_div.sv
rtl/touch_gesture_recognizer.sv
rtl/gtr_checker.sv
tb/sv/tb.sv
